// File: src/hvhe_pkg.sv
// ============================================================================
// Heading vote histogram estimator: shared package
// Widths, fixed-point constants, the arctangent table and the status struct
// shared by the top level and the digit-serial vectoring unit.
// ============================================================================
package hvhe_pkg;

  // Binary angle width used for headings (low bits of the 16-bit ports).
  localparam int AngleBits   = 16;
  localparam int HeadW       = 16;
  localparam int StrengthW   = 9;

  // Vote counters.
  localparam int Sectors     = 8;
  localparam int SectorW     = $clog2(Sectors);
  localparam int VoteW       = 8;
  localparam logic [VoteW-1:0] VoteMax        = '1;
  localparam logic [VoteW-1:0] VoteLimitReset = 8'd5;

  // Vector fixed point: 16 fractional bits, cos(45 deg) = 46341 / 65536.
  localparam int FracBits    = 16;
  localparam int DiagCoef    = 46341;

  // Vectoring unit: 32-bit words handled one 8-bit digit per cycle.
  localparam int CordicW     = 32;
  localparam int DigitW      = 8;
  localparam int NumDigits   = CordicW / DigitW;
  localparam int DigitIdxW   = $clog2(NumDigits);
  localparam int PosW        = $clog2(CordicW) + 1;
  localparam int CordicSteps = 16;
  localparam int StepW       = $clog2(CordicSteps);
  localparam int AtanIdxW    = 5;

  // Pre-rotation angles for vectors in the left half plane.
  localparam logic [CordicW-1:0] QuarterTurn      = 32'h4000_0000;
  localparam logic [CordicW-1:0] MinusQuarterTurn = 32'hC000_0000;

  // Configuration port.
  localparam int PaddrW = 3;
  localparam int PdataW = 32;
  localparam logic [0:0] RegVoteLimit = 1'b0;

  // Status from the vectoring unit back to the sequencer.
  typedef struct packed {
    logic done;      // one-cycle pulse when the angle is final
    logic null_vec;  // the input vector was exactly zero
  } cordic_sts_t;

  // atan(2^-i) as a 32-bit binary angle (2^32 is one full turn).
  function automatic logic [CordicW-1:0] atan_turn(input logic [AtanIdxW-1:0] idx);
    logic [CordicW-1:0] val;
    unique case (idx)
      5'd0:    val = 32'h2000_0000;
      5'd1:    val = 32'h12E4_051E;
      5'd2:    val = 32'h09FB_385B;
      5'd3:    val = 32'h0511_11D4;
      5'd4:    val = 32'h028B_0D43;
      5'd5:    val = 32'h0145_D7E1;
      5'd6:    val = 32'h00A2_F61E;
      5'd7:    val = 32'h0051_7C55;
      5'd8:    val = 32'h0028_BE53;
      5'd9:    val = 32'h0014_5F2F;
      5'd10:   val = 32'h000A_2F98;
      5'd11:   val = 32'h0005_17CC;
      5'd12:   val = 32'h0002_8BE6;
      5'd13:   val = 32'h0001_45F3;
      5'd14:   val = 32'h0000_A2FA;
      5'd15:   val = 32'h0000_517D;
      5'd16:   val = 32'h0000_28BE;
      5'd17:   val = 32'h0000_145F;
      5'd18:   val = 32'h0000_0A30;
      5'd19:   val = 32'h0000_0518;
      5'd20:   val = 32'h0000_028C;
      5'd21:   val = 32'h0000_0146;
      5'd22:   val = 32'h0000_00A3;
      5'd23:   val = 32'h0000_0051;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// File: src/hvhe_cordic.sv
// ============================================================================
// Digit-serial vectoring CORDIC
// Computes atan2(y, x) as a 32-bit binary angle. The x, y and angle words
// rotate through shift registers one 8-bit digit per cycle, so each
// iteration walks the word digit by digit; the adders stay eight bits wide.
// ============================================================================
module hvhe_cordic
  import hvhe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [CordicW-1:0] x_i,
  input  logic [CordicW-1:0] y_i,
  output cordic_sts_t        sts_o,
  output logic [CordicW-1:0] z_o
);

  localparam logic [DigitIdxW-1:0] LastDigit = DigitIdxW'(NumDigits - 1);
  localparam logic [StepW-1:0]     LastStep  = StepW'(CordicSteps - 1);

  // Word shift registers and per-word state.
  logic [CordicW-1:0]   x_sr_q, x_sr_d;
  logic [CordicW-1:0]   y_sr_q, y_sr_d;
  logic [CordicW-1:0]   z_sr_q, z_sr_d;
  logic                 x_sign_q, x_sign_d;
  logic                 y_sign_q, y_sign_d;
  logic                 y_nz_q, y_nz_d;
  logic                 nz_acc_q, nz_acc_d;
  logic                 cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;

  // Sequencing.
  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic                 null_q, null_d;
  logic [DigitIdxW-1:0] dig_q, dig_d;
  logic [StepW-1:0]     step_q, step_d;

  // Pre-rotation of the input vector into the right half plane.
  logic [CordicW-1:0]   x_ld, y_ld, z_ld;

  always_comb begin
    x_ld = x_i;
    y_ld = y_i;
    z_ld = '0;
    if (x_i[CordicW-1]) begin
      if (!y_i[CordicW-1]) begin
        x_ld = y_i;
        y_ld = -x_i;
        z_ld = QuarterTurn;
      end else begin
        x_ld = -y_i;
        y_ld = x_i;
        z_ld = MinusQuarterTurn;
      end
    end
  end

  // One digit of one iteration: operands are the other word shifted right
  // by the step count, read from the not yet overwritten part of its shift
  // register, with the latched sign filling in above the word.
  logic                 dir;
  logic [PosW-1:0]      avail;
  logic [PosW-1:0]      pos;
  logic [DigitW-1:0]    opx, opy, opz;
  logic [CordicW-1:0]   atan_sh;
  logic                 xsub, ysub, zsub;
  logic                 cin_x, cin_y, cin_z;
  logic [DigitW:0]      sum_x, sum_y, sum_z;

  always_comb begin
    dir     = !y_sign_q && y_nz_q;
    avail   = PosW'(CordicW - int'(dig_q) * DigitW);
    opx     = '0;
    opy     = '0;
    pos     = '0;
    for (int b = 0; b < DigitW; b++) begin
      pos    = PosW'(b) + PosW'(step_q);
      opx[b] = (pos < avail) ? y_sr_q[pos[PosW-2:0]] : y_sign_q;
      opy[b] = (pos < avail) ? x_sr_q[pos[PosW-2:0]] : x_sign_q;
    end
    atan_sh = atan_turn(AtanIdxW'(step_q)) >> (int'(dig_q) * DigitW);
    opz     = atan_sh[DigitW-1:0];

    // Positive y rotates clockwise: x grows, y shrinks, the angle grows.
    xsub  = !dir;
    ysub  = dir;
    zsub  = !dir;
    cin_x = (dig_q == '0) ? xsub : cx_q;
    cin_y = (dig_q == '0) ? ysub : cy_q;
    cin_z = (dig_q == '0) ? zsub : cz_q;
    sum_x = {1'b0, x_sr_q[DigitW-1:0]} + {1'b0, opx ^ {DigitW{xsub}}}
          + {{DigitW{1'b0}}, cin_x};
    sum_y = {1'b0, y_sr_q[DigitW-1:0]} + {1'b0, opy ^ {DigitW{ysub}}}
          + {{DigitW{1'b0}}, cin_y};
    sum_z = {1'b0, z_sr_q[DigitW-1:0]} + {1'b0, opz ^ {DigitW{zsub}}}
          + {{DigitW{1'b0}}, cin_z};
  end

  // Load, digit rotation and step counting.
  always_comb begin
    x_sr_d   = x_sr_q;
    y_sr_d   = y_sr_q;
    z_sr_d   = z_sr_q;
    x_sign_d = x_sign_q;
    y_sign_d = y_sign_q;
    y_nz_d   = y_nz_q;
    nz_acc_d = nz_acc_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    cz_d     = cz_q;
    run_d    = run_q;
    done_d   = 1'b0;
    null_d   = null_q;
    dig_d    = dig_q;
    step_d   = step_q;
    if (run_q) begin
      x_sr_d   = {sum_x[DigitW-1:0], x_sr_q[CordicW-1:DigitW]};
      y_sr_d   = {sum_y[DigitW-1:0], y_sr_q[CordicW-1:DigitW]};
      z_sr_d   = {sum_z[DigitW-1:0], z_sr_q[CordicW-1:DigitW]};
      cx_d     = sum_x[DigitW];
      cy_d     = sum_y[DigitW];
      cz_d     = sum_z[DigitW];
      nz_acc_d = ((dig_q == '0) ? 1'b0 : nz_acc_q) | (|sum_y[DigitW-1:0]);
      if (dig_q == LastDigit) begin
        // The word is complete: latch its sign and zero flag for the next step.
        dig_d    = '0;
        x_sign_d = sum_x[DigitW-1];
        y_sign_d = sum_y[DigitW-1];
        y_nz_d   = nz_acc_q | (|sum_y[DigitW-1:0]);
        if (step_q == LastStep) begin
          run_d  = 1'b0;
          done_d = 1'b1;
          step_d = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end else begin
        dig_d = dig_q + 1'b1;
      end
    end else if (start_i) begin
      x_sr_d   = x_ld;
      y_sr_d   = y_ld;
      z_sr_d   = z_ld;
      x_sign_d = x_ld[CordicW-1];
      y_sign_d = y_ld[CordicW-1];
      y_nz_d   = |y_ld;
      null_d   = (x_i == '0) && (y_i == '0);
      run_d    = 1'b1;
      dig_d    = '0;
      step_d   = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      null_q <= 1'b0;
      dig_q  <= '0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      null_q <= null_d;
      dig_q  <= dig_d;
      step_q <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    x_sr_q   <= x_sr_d;
    y_sr_q   <= y_sr_d;
    z_sr_q   <= z_sr_d;
    x_sign_q <= x_sign_d;
    y_sign_q <= y_sign_d;
    y_nz_q   <= y_nz_d;
    nz_acc_q <= nz_acc_d;
    cx_q     <= cx_d;
    cy_q     <= cy_d;
    cz_q     <= cz_d;
  end

  assign sts_o.done     = done_q;
  assign sts_o.null_vec = null_q;
  assign z_o            = z_sr_q;

endmodule

// File: src/heading_vote_histogram_estimator.sv
// ============================================================================
// Heading vote histogram estimator
// Eight 45-degree sector vote counters with decay, and the vote-weighted
// circular mean heading found by a digit-serial CORDIC.
// ============================================================================
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request: func_i = 0
//   updates the sector of sample_heading_i by the sign of strength_change_i,
//   func_i = 1 clears every counter. Each request yields exactly one result
//   on the output channel (out_valid_o / out_stall_i): estimated_heading_o
//   and no_votes_o.
//   out_valid_o rises after the vote update on the accepting edge, decay,
//   the vector sums, the CORDIC load, its 16 iterations of four 8-bit
//   digits each, the sequencer seeing the CORDIC finish and the result
//   register. One request is in flight at a time: the next is accepted
//   only once the sequencer has returned to idle.
//   A finished result sits in the output register while the next request is
//   accepted; if out_stall_i is still high when the next result is ready,
//   the block waits with in_stall_o high.
//   Reset clears all counters, sets vote_limit to 5 and empties the output.
//   vote_limit is written over the APB port at byte address 0. The user must
//   write it only while idle; the block itself does not enforce this.
// ============================================================================
module heading_vote_histogram_estimator
  import hvhe_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic signed [HeadW-1:0]     sample_heading_i,
  input  logic signed [StrengthW-1:0] strength_change_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [HeadW-1:0]     estimated_heading_o,
  output logic                        no_votes_o,
  // Configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [PaddrW-1:0]           paddr,
  input  logic [PdataW-1:0]           pwdata,
  output logic [PdataW-1:0]           prdata,
  output logic                        pready
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StDecay  = 6'b000010,
    StSums   = 6'b000100,
    StStart  = 6'b001000,
    StWait   = 6'b010000,
    StFinish = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [VoteW-1:0]   votes_q [Sectors];
  logic [VoteW-1:0]   votes_d [Sectors];
  logic [VoteW-1:0]   vote_limit_q, vote_limit_d;
  logic [CordicW-1:0] xs_q, xs_d, ys_q, ys_d;
  logic               no_votes_q, no_votes_d;
  logic               out_valid_q, out_valid_d;
  logic [HeadW-1:0]   heading_q, heading_d;
  logic               out_nv_q, out_nv_d;

  logic               in_acc;
  logic               out_free;
  cordic_sts_t        cordic_sts;
  logic [CordicW-1:0] cordic_z;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Configuration register access.
  assign pready = 1'b1;
  always_comb begin
    vote_limit_d = vote_limit_q;
    if (psel && penable && pwrite && (paddr[PaddrW-1] == RegVoteLimit)) begin
      vote_limit_d = pwdata[VoteW-1:0];
    end
  end
  assign prdata = (paddr[PaddrW-1] == RegVoteLimit) ?
                  {{(PdataW-VoteW){1'b0}}, vote_limit_q} : '0;

  // Sector selection: round the heading to the nearest 45 degrees.
  logic [AngleBits-1:0] h_rnd;
  logic [SectorW-1:0]   sec_s, sec_fwd, sec_opp, up_idx, down_idx;
  logic                 ch_neg, ch_zero;

  always_comb begin
    h_rnd    = sample_heading_i[AngleBits-1:0] + AngleBits'(1 << (AngleBits - 4));
    sec_s    = h_rnd[AngleBits-1 -: SectorW];
    sec_fwd  = sec_s + SectorW'(3);
    sec_opp  = sec_fwd + SectorW'(Sectors / 2);
    ch_neg   = strength_change_i[StrengthW-1];
    ch_zero  = (strength_change_i == '0);
    up_idx   = ch_neg ? sec_opp : sec_fwd;
    down_idx = ch_neg ? sec_fwd : sec_opp;
  end

  // Vote update, decay and the vector sums.
  logic               over_limit;
  logic               any_vote;
  logic signed [8:0]  sum_a, sum_b;
  logic signed [10:0] sum_d, sum_e;
  logic signed [CordicW-1:0] d_ext, e_ext, diag;

  always_comb begin
    over_limit = 1'b0;
    any_vote   = 1'b0;
    for (int k = 0; k < Sectors; k++) begin
      over_limit = over_limit | (votes_q[k] > vote_limit_q);
      any_vote   = any_vote | (votes_q[k] != '0);
    end
    // Sector centers: 0=-135, 1=-90, 2=-45, 3=0, 4=45, 5=90, 6=135, 7=180.
    sum_a = $signed({1'b0, votes_q[3]}) - $signed({1'b0, votes_q[7]});
    sum_b = $signed({1'b0, votes_q[5]}) - $signed({1'b0, votes_q[1]});
    sum_d = $signed({3'b000, votes_q[4]}) - $signed({3'b000, votes_q[6]})
          - $signed({3'b000, votes_q[0]}) + $signed({3'b000, votes_q[2]});
    sum_e = $signed({3'b000, votes_q[4]}) + $signed({3'b000, votes_q[6]})
          - $signed({3'b000, votes_q[0]}) - $signed({3'b000, votes_q[2]});
    d_ext = CordicW'(sum_d);
    e_ext = CordicW'(sum_e);
    diag  = CordicW'(DiagCoef);
  end

  always_comb begin
    state_d     = state_q;
    votes_d     = votes_q;
    xs_d        = xs_q;
    ys_d        = ys_q;
    no_votes_d  = no_votes_q;
    out_valid_d = out_valid_q;
    heading_d   = heading_q;
    out_nv_d    = out_nv_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (func_i) begin
            for (int k = 0; k < Sectors; k++) begin
              votes_d[k] = '0;
            end
          end else if (!ch_zero) begin
            for (int k = 0; k < Sectors; k++) begin
              if ((SectorW'(k) == up_idx) && (votes_q[k] != VoteMax)) begin
                votes_d[k] = votes_q[k] + 1'b1;
              end else if ((SectorW'(k) == down_idx) && (votes_q[k] != '0)) begin
                votes_d[k] = votes_q[k] - 1'b1;
              end
            end
          end
          state_d = StDecay;
        end
      end
      StDecay: begin
        // Any counter above the limit pulls every nonzero counter down by one.
        if (over_limit) begin
          for (int k = 0; k < Sectors; k++) begin
            if (votes_q[k] != '0) begin
              votes_d[k] = votes_q[k] - 1'b1;
            end
          end
        end
        state_d = StSums;
      end
      StSums: begin
        xs_d       = {{(CordicW-9-FracBits){sum_a[8]}}, sum_a, {FracBits{1'b0}}}
                   + CordicW'(d_ext * diag);
        ys_d       = {{(CordicW-9-FracBits){sum_b[8]}}, sum_b, {FracBits{1'b0}}}
                   + CordicW'(e_ext * diag);
        no_votes_d = !any_vote;
        state_d    = StStart;
      end
      StStart: begin
        state_d = StWait;
      end
      StWait: begin
        if (cordic_sts.done) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (out_free) begin
          // Round the 32-bit angle to the output angle width.
          if (no_votes_q || cordic_sts.null_vec) begin
            heading_d = '0;
          end else begin
            heading_d = HeadW'(cordic_z[CordicW-1 -: AngleBits]
                      + AngleBits'(cordic_z[CordicW-1-AngleBits]));
          end
          out_nv_d    = no_votes_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  hvhe_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == StStart),
    .x_i     (xs_q),
    .y_i     (ys_q),
    .sts_o   (cordic_sts),
    .z_o     (cordic_z)
  );

  // Control state and vote counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      vote_limit_q <= VoteLimitReset;
      out_valid_q  <= 1'b0;
      for (int k = 0; k < Sectors; k++) begin
        votes_q[k] <= '0;
      end
    end else begin
      state_q      <= state_d;
      vote_limit_q <= vote_limit_d;
      out_valid_q  <= out_valid_d;
      votes_q      <= votes_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    xs_q       <= xs_d;
    ys_q       <= ys_d;
    no_votes_q <= no_votes_d;
    heading_q  <= heading_d;
    out_nv_q   <= out_nv_d;
  end

  assign in_stall_o          = (state_q != StIdle);
  assign out_valid_o         = out_valid_q;
  assign estimated_heading_o = heading_q;
  assign no_votes_o          = out_nv_q;

endmodule
